/* sv/gcr62_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr62_pkg
// Shared types, image layout positions and the code table of the 6-and-2
// sector encoder.
// ----------------------------------------------------------------------------
package gcr62_pkg;

  // result status codes, also used as the kind of a queued item
  typedef enum logic [1:0] {
    StPushOk  = 2'd0,
    StEmit    = 2'd1,
    StPushRej = 2'd2,
    StNotRdy  = 2'd3
  } status_e;

  // region of the track image that an emitted byte falls in
  typedef enum logic [3:0] {
    RgSync    = 4'd0,
    RgAddrPro = 4'd1,
    RgAddrFld = 4'd2,
    RgAddrEpi = 4'd3,
    RgGap     = 4'd4,
    RgDataPro = 4'd5,
    RgAux     = 4'd6,
    RgHigh    = 4'd7,
    RgCsum    = 4'd8,
    RgDataEpi = 4'd9
  } region_e;

  // sector and lane storage geometry
  localparam int unsigned SecDepth  = 256;
  localparam int unsigned SecAw     = $clog2(SecDepth);
  localparam int unsigned LaneDepth = 86;
  localparam int unsigned LaneAw    = $clog2(LaneDepth);
  localparam logic [LaneAw-1:0] LaneLast = LaneAw'(LaneDepth - 1);
  // third lane only holds bytes 172..255, so its top two entries read as zero
  localparam logic [LaneAw-1:0] Lane2Limit = LaneAw'(SecDepth - 2 * LaneDepth);

  localparam logic [1:0] LaneA = 2'd0;
  localparam logic [1:0] LaneB = 2'd1;
  localparam logic [1:0] LaneC = 2'd2;

  // image layout, by emit position
  localparam int unsigned PosW = 9;
  localparam logic [PosW-1:0] AddrProPos = 9'd37;
  localparam logic [PosW-1:0] AddrFldPos = 9'd40;
  localparam logic [PosW-1:0] AddrEpiPos = 9'd48;
  localparam logic [PosW-1:0] GapPos     = 9'd51;
  localparam logic [PosW-1:0] DataProPos = 9'd67;
  localparam logic [PosW-1:0] AuxPos     = 9'd70;
  localparam logic [PosW-1:0] HighPos    = 9'd156;
  localparam logic [PosW-1:0] CsumPos    = 9'd412;
  localparam logic [PosW-1:0] DataEpiPos = 9'd413;
  localparam logic [PosW-1:0] LastPos    = 9'd415;

  // mark bytes
  localparam logic [7:0] SyncByte  = 8'hff;
  localparam logic [7:0] MarkD5    = 8'hd5;
  localparam logic [7:0] MarkAa    = 8'haa;
  localparam logic [7:0] MarkAddr  = 8'h96;
  localparam logic [7:0] MarkData  = 8'had;
  localparam logic [7:0] MarkDe    = 8'hde;
  localparam logic [7:0] MarkEb    = 8'heb;
  localparam logic [7:0] VolumeRst = 8'd254;

  // queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = $clog2(QDepth);

  // one classified item as it travels from front to back
  typedef struct packed {
    status_e            kind;
    region_e            region;
    logic [7:0]         idx;
    logic [LaneAw-1:0]  lidx;
    logic [1:0]         lane;
    logic [7:0]         data;
    logic [7:0]         track;
    logic [7:0]         sector;
    logic               first;
    logic               last;
  } entry_t;

  // 6-and-2 write table
  localparam logic [7:0] GcrTable [64] = '{
    8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
    8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
    8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
    8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
    8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
    8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
    8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
    8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
  };

  // low two bits swapped, as packed into the auxiliary nibbles
  function automatic logic [1:0] swap2(input logic [1:0] v);
    swap2 = {v[0], v[1]};
  endfunction

endpackage

/* sv/gcr62_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr62_front
// Accepts items, tracks load and emit progress and classifies each item
// into a queue entry for the back end.
// ----------------------------------------------------------------------------
module gcr62_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [7:0]         data_byte_i,
  input  logic [7:0]         track_number_i,
  input  logic [7:0]         sector_number_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output gcr62_pkg::entry_t  q_entry_o
);

  logic                           emitting_q, emitting_d;
  logic [gcr62_pkg::SecAw-1:0]    load_cnt_q, load_cnt_d;
  logic [1:0]                     lane_q, lane_d;
  logic [gcr62_pkg::LaneAw-1:0]   lidx_q, lidx_d;
  logic [gcr62_pkg::PosW-1:0]     pos_q, pos_d;
  logic [gcr62_pkg::PosW-1:0]     off;
  gcr62_pkg::region_e             region;
  logic                           accept;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign q_push_o   = accept;

  // region of the current emit position and the offset inside it
  always_comb begin
    region = gcr62_pkg::RgSync;
    off    = '0;
    priority if (pos_q < gcr62_pkg::AddrProPos) begin
      region = gcr62_pkg::RgSync;
    end else if (pos_q < gcr62_pkg::AddrFldPos) begin
      region = gcr62_pkg::RgAddrPro;
      off    = pos_q - gcr62_pkg::AddrProPos;
    end else if (pos_q < gcr62_pkg::AddrEpiPos) begin
      region = gcr62_pkg::RgAddrFld;
      off    = pos_q - gcr62_pkg::AddrFldPos;
    end else if (pos_q < gcr62_pkg::GapPos) begin
      region = gcr62_pkg::RgAddrEpi;
      off    = pos_q - gcr62_pkg::AddrEpiPos;
    end else if (pos_q < gcr62_pkg::DataProPos) begin
      region = gcr62_pkg::RgGap;
    end else if (pos_q < gcr62_pkg::AuxPos) begin
      region = gcr62_pkg::RgDataPro;
      off    = pos_q - gcr62_pkg::DataProPos;
    end else if (pos_q < gcr62_pkg::HighPos) begin
      region = gcr62_pkg::RgAux;
      off    = pos_q - gcr62_pkg::AuxPos;
    end else if (pos_q < gcr62_pkg::CsumPos) begin
      region = gcr62_pkg::RgHigh;
      off    = pos_q - gcr62_pkg::HighPos;
    end else if (pos_q == gcr62_pkg::CsumPos) begin
      region = gcr62_pkg::RgCsum;
    end else begin
      region = gcr62_pkg::RgDataEpi;
      off    = pos_q - gcr62_pkg::DataEpiPos;
    end
  end

  // classify the item and advance the counters
  always_comb begin
    emitting_d = emitting_q;
    load_cnt_d = load_cnt_q;
    lane_d     = lane_q;
    lidx_d     = lidx_q;
    pos_d      = pos_q;

    q_entry_o        = '0;
    q_entry_o.data   = data_byte_i;
    q_entry_o.track  = track_number_i;
    q_entry_o.sector = sector_number_i;
    q_entry_o.lane   = lane_q;
    q_entry_o.lidx   = lidx_q;
    q_entry_o.region = region;

    if (!opcode_i) begin
      if (emitting_q) begin
        q_entry_o.kind = gcr62_pkg::StPushRej;
      end else begin
        q_entry_o.kind  = gcr62_pkg::StPushOk;
        q_entry_o.idx   = load_cnt_q;
        q_entry_o.first = (load_cnt_q == '0);
        if (accept) begin
          load_cnt_d = load_cnt_q + 1'b1;
          if (lidx_q == gcr62_pkg::LaneLast) begin
            lidx_d = '0;
            lane_d = lane_q + 1'b1;
          end else begin
            lidx_d = lidx_q + 1'b1;
          end
          // sector complete: start emitting from the top of the image
          if (load_cnt_q == '1) begin
            emitting_d = 1'b1;
            pos_d      = '0;
            lane_d     = gcr62_pkg::LaneA;
            lidx_d     = '0;
          end
        end
      end
    end else begin
      if (!emitting_q) begin
        q_entry_o.kind = gcr62_pkg::StNotRdy;
      end else begin
        q_entry_o.kind = gcr62_pkg::StEmit;
        q_entry_o.idx  = off[7:0];
        q_entry_o.lidx = off[gcr62_pkg::LaneAw-1:0];
        q_entry_o.last = (pos_q == gcr62_pkg::LastPos);
        if (accept) begin
          if (pos_q == gcr62_pkg::LastPos) begin
            emitting_d = 1'b0;
            pos_d      = '0;
            load_cnt_d = '0;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
      end
    end
  end

  // progress registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emitting_q <= 1'b0;
      load_cnt_q <= '0;
      lane_q     <= gcr62_pkg::LaneA;
      lidx_q     <= '0;
      pos_q      <= '0;
    end else begin
      emitting_q <= emitting_d;
      load_cnt_q <= load_cnt_d;
      lane_q     <= lane_d;
      lidx_q     <= lidx_d;
      pos_q      <= pos_d;
    end
  end

endmodule

/* sv/gcr62_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr62_queue
// Short first-in first-out queue of classified items between the front
// and the back end.
// ----------------------------------------------------------------------------
module gcr62_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  gcr62_pkg::entry_t  push_entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output gcr62_pkg::entry_t  head_o
);

  gcr62_pkg::entry_t            slots_q [gcr62_pkg::QDepth];
  logic [gcr62_pkg::QAw-1:0]    wr_ptr_q, wr_ptr_d;
  logic [gcr62_pkg::QAw-1:0]    rd_ptr_q, rd_ptr_d;
  logic [gcr62_pkg::QAw:0]      count_q, count_d;

  assign full_o  = (count_q == (gcr62_pkg::QAw+1)'(gcr62_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == gcr62_pkg::QAw'(gcr62_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == gcr62_pkg::QAw'(gcr62_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

/* sv/gcr62_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr62_back
// Carries out queued items: stores sector bytes, reads them back while
// emitting, runs the XOR chain through the write table and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module gcr62_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         volume_i,
  input  logic               q_empty_i,
  input  gcr62_pkg::entry_t  q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [7:0]         encoded_byte_o,
  output logic               last_byte_flag_o
);

  // sector bytes and the swapped low bit pairs, one lane per third
  logic [7:0] sec_mem   [gcr62_pkg::SecDepth];
  logic [1:0] lane0_mem [gcr62_pkg::LaneDepth];
  logic [1:0] lane1_mem [gcr62_pkg::LaneDepth];
  logic [1:0] lane2_mem [gcr62_pkg::LaneDepth];

  logic [7:0]         sec_rd_q;
  logic [1:0]         lane0_rd_q, lane1_rd_q, lane2_rd_q;
  logic               s1_valid_q;
  gcr62_pkg::entry_t  s1_q;
  logic               s1_adv;

  logic [7:0]         track_q, sector_q;
  logic [5:0]         chain_q, chain_d;

  logic               out_valid_q;
  logic [1:0]         status_q;
  logic [7:0]         byte_q, byte_d;
  logic               last_q;

  logic [5:0]         six;
  logic [1:0]         lane2_bits;
  logic [7:0]         fld_val;
  logic               push_ok;

  assign s1_adv  = s1_valid_q & (~out_valid_q | out_ready_i);
  assign q_pop_o = ~q_empty_i & (~s1_valid_q | s1_adv);
  assign push_ok = q_pop_o & (q_head_i.kind == gcr62_pkg::StPushOk);

  // storage: written on an accepted push, read as an item enters the stage
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      sec_mem[q_head_i.idx] <= q_head_i.data;
      if (q_head_i.lane == gcr62_pkg::LaneA) begin
        lane0_mem[q_head_i.lidx] <= gcr62_pkg::swap2(q_head_i.data[1:0]);
      end
      if (q_head_i.lane == gcr62_pkg::LaneB) begin
        lane1_mem[q_head_i.lidx] <= gcr62_pkg::swap2(q_head_i.data[1:0]);
      end
      if (q_head_i.lane == gcr62_pkg::LaneC) begin
        lane2_mem[q_head_i.lidx] <= gcr62_pkg::swap2(q_head_i.data[1:0]);
      end
    end
    if (q_pop_o) begin
      sec_rd_q   <= sec_mem[q_head_i.idx];
      lane0_rd_q <= lane0_mem[q_head_i.lidx];
      lane1_rd_q <= lane1_mem[q_head_i.lidx];
      lane2_rd_q <= lane2_mem[q_head_i.lidx];
    end
  end

  // read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_q <= q_head_i;
    end
  end

  // track and sector latched by the first push of a sector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q  <= '0;
      sector_q <= '0;
    end else if (push_ok && q_head_i.first) begin
      track_q  <= q_head_i.track;
      sector_q <= q_head_i.sector;
    end
  end

  // image byte for the item in the read stage
  always_comb begin
    lane2_bits = (s1_q.lidx < gcr62_pkg::Lane2Limit) ? lane2_rd_q : 2'b00;
    six        = {lane2_bits, lane1_rd_q, lane0_rd_q};

    unique case (s1_q.idx[2:1])
      2'd0:    fld_val = volume_i;
      2'd1:    fld_val = track_q;
      2'd2:    fld_val = sector_q;
      default: fld_val = volume_i ^ track_q ^ sector_q;
    endcase

    chain_d = chain_q;
    byte_d  = gcr62_pkg::SyncByte;
    unique case (s1_q.region)
      gcr62_pkg::RgSync, gcr62_pkg::RgGap: begin
        byte_d  = gcr62_pkg::SyncByte;
        chain_d = '0;
      end
      gcr62_pkg::RgAddrPro, gcr62_pkg::RgDataPro: begin
        unique case (s1_q.idx[1:0])
          2'd0:    byte_d = gcr62_pkg::MarkD5;
          2'd1:    byte_d = gcr62_pkg::MarkAa;
          default: byte_d = (s1_q.region == gcr62_pkg::RgAddrPro) ?
                            gcr62_pkg::MarkAddr : gcr62_pkg::MarkData;
        endcase
      end
      gcr62_pkg::RgAddrEpi, gcr62_pkg::RgDataEpi: begin
        unique case (s1_q.idx[1:0])
          2'd0:    byte_d = gcr62_pkg::MarkDe;
          2'd1:    byte_d = gcr62_pkg::MarkAa;
          default: byte_d = gcr62_pkg::MarkEb;
        endcase
      end
      gcr62_pkg::RgAddrFld: begin
        // 4-and-4: odd bits first, then even bits
        byte_d = (s1_q.idx[0] ? fld_val : {1'b0, fld_val[7:1]}) | gcr62_pkg::MarkAa;
      end
      gcr62_pkg::RgAux: begin
        byte_d  = gcr62_pkg::GcrTable[chain_q ^ six];
        chain_d = six;
      end
      gcr62_pkg::RgHigh: begin
        byte_d  = gcr62_pkg::GcrTable[chain_q ^ sec_rd_q[7:2]];
        chain_d = sec_rd_q[7:2];
      end
      gcr62_pkg::RgCsum: begin
        byte_d = gcr62_pkg::GcrTable[chain_q];
      end
      default: begin
        byte_d = gcr62_pkg::SyncByte;
      end
    endcase
  end

  // chain register moves only with an emitted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
    end else if (s1_adv && (s1_q.kind == gcr62_pkg::StEmit)) begin
      chain_q <= chain_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      status_q <= s1_q.kind;
      byte_q   <= (s1_q.kind == gcr62_pkg::StEmit) ? byte_d : 8'h00;
      last_q   <= s1_q.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign encoded_byte_o   = byte_q;
  assign last_byte_flag_o = last_q;

endmodule

/* sv/gcr_6_and_2_sector_encoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_6_and_2_sector_encoder_unit
// 6-and-2 GCR sector encoder: loads a 256-byte sector, then emits the
// 416-byte track image one byte per pull.
// ----------------------------------------------------------------------------
// Each item (push of a sector byte or pull of an image byte) gives exactly
// one result. The block takes one item per cycle when the output side keeps
// up; an accepted item passes through the two-entry queue, the registered
// read of the sector memory and the output register before its result
// leaves. No clearing pass is needed after reset. The volume register
// may be written only while no item is in flight and is read when the
// address field bytes are produced.
module gcr_6_and_2_sector_encoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] track_number_i,
  input  logic [7:0] sector_number_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [7:0] encoded_byte_o,
  output logic       last_byte_flag_o
);

  logic [7:0]         volume_val_q;
  logic               q_push, q_pop, q_full, q_empty;
  gcr62_pkg::entry_t  q_in, q_head;

  // volume register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_val_q <= gcr62_pkg::VolumeRst;
    end else if (cfg_we_i) begin
      volume_val_q <= cfg_wdata_i;
    end
  end

  // front: accept and classify
  gcr62_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .data_byte_i     (data_byte_i),
    .track_number_i  (track_number_i),
    .sector_number_i (sector_number_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_entry_o       (q_in)
  );

  // queue between front and back
  gcr62_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_in),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .empty_o      (q_empty),
    .head_o       (q_head)
  );

  // back: storage, chain and results
  gcr62_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .volume_i         (volume_val_q),
    .q_empty_i        (q_empty),
    .q_head_i         (q_head),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .encoded_byte_o   (encoded_byte_o),
    .last_byte_flag_o (last_byte_flag_o)
  );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives whole sectors into the 6-and-2 sector encoder and pulls the track
// images back out, with rejected pushes and early pulls mixed in. Every
// reply is checked against an in-bench encoder that tracks load, emission
// and the nibble chain. The volume register is rewritten between phases,
// including part way through an image, before or after its address field.
// ----------------------------------------------------------------------------
module testbench;

  // item opcodes
  localparam logic OpPush = 1'b0;
  localparam logic OpPull = 1'b1;

  // track image layout by emit position
  localparam int unsigned ImageLen  = 416;
  localparam int unsigned AddrStart = 37;
  localparam int unsigned AddrVals  = 40;
  localparam int unsigned AddrEnd   = 48;
  localparam int unsigned GapStart  = 51;
  localparam int unsigned DataStart = 67;
  localparam int unsigned AuxStart  = 70;
  localparam int unsigned HighStart = 156;
  localparam int unsigned CsumPos   = 412;
  localparam int unsigned EpiPos    = 413;
  localparam int unsigned AuxCount  = 86;
  localparam int unsigned SectorLen = 256;

  localparam logic [7:0] FillByte   = 8'hff;
  localparam logic [7:0] OddEvenPad = 8'haa;
  localparam logic [0:2][7:0] AddrMarks = {8'hd5, 8'haa, 8'h96};
  localparam logic [0:2][7:0] DataMarks = {8'hd5, 8'haa, 8'had};
  localparam logic [0:2][7:0] EndMarks  = {8'hde, 8'haa, 8'heb};
  localparam logic [7:0] VolumeDefault  = 8'd254;

  // six-bit value to disk nibble
  localparam logic [0:63][7:0] NibbleCode = {
    8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
    8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
    8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
    8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
    8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
    8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
    8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
    8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
  };

  localparam int WatchLimit   = 2000;
  localparam int DrainCycles  = 8;
  localparam int TargetItems  = 1750;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
    logic [7:0] track_number;
    logic [7:0] sector_number;
  } disk_request_t;

  typedef struct packed {
    gcr62_pkg::status_e status;
    logic [7:0]         encoded_byte;
    logic               last_byte_flag;
  } disk_reply_t;

  // dut ports
  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       cfg_we_i        = 1'b0;
  logic [7:0] cfg_wdata_i     = 8'h00;
  logic       in_valid_i      = 1'b0;
  logic       in_ready_o;
  logic       opcode_i        = 1'b0;
  logic [7:0] data_byte_i     = 8'h00;
  logic [7:0] track_number_i  = 8'h00;
  logic [7:0] sector_number_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i     = 1'b0;
  logic [1:0] status_o;
  logic [7:0] encoded_byte_o;
  logic       last_byte_flag_o;

  // encoder state as the bench sees it
  logic [7:0] vol_reg;
  logic [7:0] sector_mem [SectorLen];
  logic [7:0] aux_mem [AuxCount];
  logic [8:0] load_cnt;
  logic [8:0] emit_pos;
  logic [5:0] chain6;
  logic [7:0] trk_latch;
  logic [7:0] sec_latch;
  bit         emitting;

  disk_request_t queued_requests [$];
  disk_reply_t   predicted_replies [$];
  disk_request_t drive_req;
  disk_reply_t   want;

  int send_gap     = 0;
  int recv_stall   = 0;
  bit calm_send    = 1'b0;
  bit calm_recv    = 1'b0;
  int quiet_cycles = 0;
  int err_count    = 0;

  gcr_6_and_2_sector_encoder_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .data_byte_i      (data_byte_i),
    .track_number_i   (track_number_i),
    .sector_number_i  (sector_number_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .encoded_byte_o   (encoded_byte_o),
    .last_byte_flag_o (last_byte_flag_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // encoder prediction
  // ---------------------------------------------------------------------------
  function automatic void clear_encoder();
    vol_reg   = VolumeDefault;
    load_cnt  = '0;
    emit_pos  = '0;
    chain6    = '0;
    trk_latch = '0;
    sec_latch = '0;
    emitting  = 1'b0;
    foreach (aux_mem[j]) aux_mem[j] = '0;
  endfunction

  // xor chain through the nibble code
  function automatic logic [7:0] chain_nibble(input logic [5:0] six);
    logic [7:0] code;
    code   = NibbleCode[chain6 ^ six];
    chain6 = six;
    return code;
  endfunction

  // 4-and-4 halves: odd bits first, then even bits
  function automatic logic [7:0] odd_even(input logic [7:0] v, input bit second);
    return (second ? v : (v >> 1)) | OddEvenPad;
  endfunction

  function automatic logic [7:0] track_image_byte(input int unsigned p);
    int unsigned q;
    int unsigned k;
    logic [7:0]  v;
    logic [7:0]  aux;
    if (p < AddrStart) return FillByte;
    if (p < AddrVals) return AddrMarks[p - AddrStart];
    if (p < AddrEnd) begin
      q = p - AddrVals;
      case (q >> 1)
        0:       v = vol_reg;
        1:       v = trk_latch;
        2:       v = sec_latch;
        default: v = vol_reg ^ trk_latch ^ sec_latch;
      endcase
      return odd_even(v, q[0]);
    end
    if (p < GapStart) return EndMarks[p - AddrEnd];
    if (p < DataStart) return FillByte;
    if (p < AuxStart) return DataMarks[p - DataStart];
    if (p < HighStart) begin
      // aux nibbles go out from the top entry down
      k   = AuxCount - 1 - (p - AuxStart);
      aux = aux_mem[k];
      // the two bottom entries only ever took two shifts
      if (k < 2) aux = aux >> 2;
      return chain_nibble(aux[5:0]);
    end
    if (p < CsumPos) return chain_nibble(sector_mem[p - HighStart][7:2]);
    if (p == CsumPos) return NibbleCode[chain6];
    return EndMarks[p - EpiPos];
  endfunction

  function automatic disk_reply_t predict_reply(input disk_request_t req);
    disk_reply_t r;
    int unsigned idx;
    int unsigned k;
    r.status         = gcr62_pkg::StPushOk;
    r.encoded_byte   = 8'h00;
    r.last_byte_flag = 1'b0;
    if (req.opcode == OpPush) begin
      if (emitting) begin
        r.status = gcr62_pkg::StPushRej;
      end else begin
        idx = load_cnt[7:0];
        // first byte of a sector latches the address and clears the aux nibbles
        if (load_cnt == 0) begin
          trk_latch = req.track_number;
          sec_latch = req.sector_number;
          foreach (aux_mem[j]) aux_mem[j] = '0;
        end
        sector_mem[idx] = req.data_byte;
        k = AuxCount - 1 - (idx % AuxCount);
        aux_mem[k] = (aux_mem[k] >> 2)
                   | {2'b00, req.data_byte[0], req.data_byte[1], 4'b0000};
        load_cnt = load_cnt + 9'd1;
        if (load_cnt >= SectorLen) begin
          emitting = 1'b1;
          emit_pos = '0;
          chain6   = '0;
        end
      end
    end else if (!emitting) begin
      r.status = gcr62_pkg::StNotRdy;
    end else begin
      r.status       = gcr62_pkg::StEmit;
      r.encoded_byte = track_image_byte(emit_pos);
      if (emit_pos == ImageLen - 1) begin
        r.last_byte_flag = 1'b1;
        emitting = 1'b0;
        load_cnt = '0;
        emit_pos = '0;
      end else begin
        emit_pos = emit_pos + 9'd1;
      end
    end
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predicted_replies.push_back(predict_reply(drive_req));
        if ($urandom_range(0, 299) == 0) calm_send = !calm_send;
        send_gap = calm_send ? 0 : pick_gap();
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap   = send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (queued_requests.size() > 0) begin
          drive_req       = queued_requests.pop_front();
          in_valid_i      <= 1'b1;
          opcode_i        <= drive_req.opcode;
          data_byte_i     <= drive_req.data_byte;
          track_number_i  <= drive_req.track_number;
          sector_number_i <= drive_req.sector_number;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // reply monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_replies.size() == 0) begin
          $error("reply with none pending: status %0d byte %02h", status_o, encoded_byte_o);
          err_count++;
        end else begin
          want = predicted_replies.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            err_count++;
          end
          if (encoded_byte_o !== want.encoded_byte) begin
            $error("encoded_byte: expected %02h, got %02h", want.encoded_byte, encoded_byte_o);
            err_count++;
          end
          if (last_byte_flag_o !== want.last_byte_flag) begin
            $error("last_byte_flag: expected %0d, got %0d",
                   want.last_byte_flag, last_byte_flag_o);
            err_count++;
          end
        end
      end
      // receiver stalls
      if (recv_stall > 0) begin
        recv_stall  = recv_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 399) == 0) calm_recv = !calm_recv;
        if (!calm_recv && $urandom_range(0, 5) == 0) recv_stall = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic add_item(input logic op, input logic [7:0] d, input logic [7:0] t,
                          input logic [7:0] s);
    disk_request_t req;
    req.opcode        = op;
    req.data_byte     = d;
    req.track_number  = t;
    req.sector_number = s;
    queued_requests.push_back(req);
  endtask

  // sector bytes, with early pulls mixed in
  task automatic load_bytes(input int count, input int noise_pct);
    for (int n = 0; n < count; n++) begin
      while ($urandom_range(0, 99) < noise_pct)
        add_item(OpPull, 8'($urandom), 8'($urandom), 8'($urandom));
      add_item(OpPush, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // image pulls, with rejected pushes mixed in
  task automatic pull_bytes(input int count, input int noise_pct);
    for (int n = 0; n < count; n++) begin
      while ($urandom_range(0, 99) < noise_pct)
        add_item(OpPush, 8'($urandom), 8'($urandom), 8'($urandom));
      add_item(OpPull, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // sender holds off until every reply is back and the pipe is empty
  task automatic wait_drained();
    do @(negedge clk_i);
    while (queued_requests.size() != 0 || in_valid_i || predicted_replies.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_volume(input logic [7:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    vol_reg     = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_volume(input int n);
    case (n)
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    int loaded;
    int split;
    int noise;
    int sectors;
    int vol_writes;
    loaded     = 0;
    sectors    = 0;
    vol_writes = 0;
    noise      = 5;
    clear_encoder();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: early pulls, extreme bytes and addresses, swapped low bits
    add_item(OpPull, 8'h00, 8'h00, 8'h00);
    add_item(OpPull, 8'hff, 8'hff, 8'hff);
    add_item(OpPush, 8'hff, 8'hff, 8'h00);
    add_item(OpPush, 8'h00, 8'h00, 8'hff);
    add_item(OpPush, 8'h01, 8'($urandom), 8'($urandom));
    add_item(OpPush, 8'h02, 8'($urandom), 8'($urandom));
    add_item(OpPush, 8'h03, 8'($urandom), 8'($urandom));
    add_item(OpPull, 8'($urandom), 8'($urandom), 8'($urandom));
    add_item(OpPush, 8'haa, 8'($urandom), 8'($urandom));
    add_item(OpPush, 8'h55, 8'($urandom), 8'($urandom));
    add_item(OpPush, 8'h80, 8'($urandom), 8'($urandom));
    add_item(OpPush, 8'h7f, 8'($urandom), 8'($urandom));
    loaded = 9;

    // whole sectors with random content
    while (loaded + SectorLen + ImageLen <= TargetItems) begin
      noise = $urandom_range(2, 10);
      load_bytes((sectors == 0) ? SectorLen - 9 : SectorLen, noise);
      wait_drained();
      if (sectors > 0) begin
        write_volume(pick_volume(vol_writes));
        vol_writes++;
      end
      // first image keeps the reset volume through its address field
      split = (sectors == 0) ? AddrEnd : $urandom_range(0, GapStart - 1);
      pull_bytes(split, noise);
      wait_drained();
      // volume change part way through the image
      write_volume(pick_volume(vol_writes));
      vol_writes++;
      pull_bytes(ImageLen - split, noise);
      wait_drained();
      write_volume(pick_volume(vol_writes));
      vol_writes++;
      loaded  = loaded + ((sectors == 0) ? SectorLen - 9 : SectorLen) + ImageLen;
      sectors++;
    end

    // last sector, pulled only part way to keep to the item budget
    if (loaded + SectorLen < TargetItems) begin
      load_bytes(SectorLen, noise);
      wait_drained();
      pull_bytes(TargetItems - loaded - SectorLen, noise);
    end

    wait_drained();
    if (err_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
